// ===== hw/rtl/vqdm_pkg.sv =====
// Shared types and constants for the virtqueue descriptor manager.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package vqdm_pkg;

  // Default sizing of the descriptor table and of the stored cookies.
  localparam int MAX_QUEUE_DEF   = 256;
  localparam int COOKIE_BITS_DEF = 32;

  // Reset value of the queue size register (log2 of the size).
  localparam logic [3:0] QLOG_RESET = 4'd8;

  // Stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 216;

  // Result kinds, carried in out_tuser.
  typedef enum logic [2:0] {
    KIND_DESC    = 3'd0,
    KIND_PUBLISH = 3'd1,
    KIND_RECLAIM = 3'd2,
    KIND_EMPTY   = 3'd3,
    KIND_NOFREE  = 3'd4
  } kind_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_ADD_PUB,
    ST_RC_CHK,
    ST_RC_RD,
    ST_RC_WALK
  } state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_ADD_FULL,
    OP_ADD_READ,
    OP_ADD_WRITE,
    OP_ADD_PUB,
    OP_RC_NONE,
    OP_RC_START,
    OP_RC_READ,
    OP_RC_STEP,
    OP_RC_FINISH
  } dp_op_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;        // no free descriptor
    logic no_work;     // used index equals last seen index
    logic chain_end;   // latched add closes its chain
    logic walk_more;   // returned chain continues past current descriptor
    logic clear_last;  // clearing pass writes its final entry
    logic out_free;    // output register can take a beat this cycle
  } dp_stat_t;

  // One input item.
  typedef struct packed {
    logic        cmd;
    logic [63:0] buf_addr;
    logic        buf_write;
    logic [31:0] buf_len;
    logic        chain_end;
    logic [31:0] cookie_in;
    logic [15:0] device_used_index;
    logic [15:0] used_head;
    logic [31:0] used_length;
  } in_beat_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  slot;
    logic [63:0] desc_address;
    logic [31:0] desc_length;
    logic [1:0]  desc_flag_bits;
    logic [7:0]  head_index;
    logic [15:0] avail_index;
    logic [31:0] cookie_out;
    logic [31:0] returned_length;
    logic [8:0]  freed;
    logic [8:0]  free_count;
    logic        last;
  } out_beat_t;

endpackage

// ===== hw/rtl/virtqueue_descriptor_manager_core.sv =====
// Top level of the virtqueue descriptor manager: stream ports, controller
// and datapath. Depends on vqdm_pkg, vqdm_ctrl and vqdm_datapath.
//
// Driver side of a split virtio queue. One item is worked at a time. An add
// beat runs through accept, link read and descriptor write, plus a publish
// step when it ends a chain; an add with no free descriptor and a reclaim
// with nothing used run through accept and one result step. A reclaim that
// finds work hooks the chain to the free list, then walks the returned
// chain with one link memory read per descriptor before its result step.
// Output stalls hold the result steps; the next input beat is taken while a
// result beat still waits. After reset and after every write of the queue
// size register a clearing pass rebuilds the free list at one entry per
// cycle over all queue size entries, during which no input beat is taken.
module virtqueue_descriptor_manager_core #(
  parameter int MAX_QUEUE   = vqdm_pkg::MAX_QUEUE_DEF,
  parameter int COOKIE_BITS = vqdm_pkg::COOKIE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Queue size register: log2 of descriptors in use.
  input  logic                            cfg_wr_en,
  input  logic [3:0]                      cfg_wr_data,
  // in_tdata, from bit 0: buf_addr(64), buf_write(1), buf_len(32),
  // cookie_in(32), device_used_index(16), used_head(16), used_length(32).
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [vqdm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [0:0]                      in_tuser,   // cmd(1)
  input  logic                            in_tlast,   // chain_end
  // out_tdata, from bit 0: slot(8), desc_address(64), desc_length(32),
  // desc_flag_bits(2), head_index(8), avail_index(16), cookie_out(32),
  // returned_length(32), freed(9), free_count(9).
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [vqdm_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [2:0]                       out_tuser,  // kind(3)
  output logic                             out_tlast   // last
);

  vqdm_pkg::in_beat_t  in_beat;
  vqdm_pkg::out_beat_t out_beat;
  vqdm_pkg::dp_op_t    op;
  vqdm_pkg::dp_stat_t  stat;

  // Unpack the input beat.
  assign in_beat.cmd               = in_tuser[0];
  assign in_beat.buf_addr          = in_tdata[63:0];
  assign in_beat.buf_write         = in_tdata[64];
  assign in_beat.buf_len           = in_tdata[96:65];
  assign in_beat.chain_end         = in_tlast;
  assign in_beat.cookie_in         = in_tdata[128:97];
  assign in_beat.device_used_index = in_tdata[144:129];
  assign in_beat.used_head         = in_tdata[160:145];
  assign in_beat.used_length       = in_tdata[192:161];

  // Pack the result beat.
  assign out_tdata = {4'b0, out_beat.free_count, out_beat.freed,
                      out_beat.returned_length, out_beat.cookie_out,
                      out_beat.avail_index, out_beat.head_index,
                      out_beat.desc_flag_bits, out_beat.desc_length,
                      out_beat.desc_address, out_beat.slot};
  assign out_tuser = out_beat.kind;
  assign out_tlast = out_beat.last;

  vqdm_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .in_tvalid     (in_tvalid),
    .in_is_reclaim (in_tuser[0]),
    .in_tready     (in_tready),
    .stat          (stat),
    .op            (op)
  );

  vqdm_datapath #(
    .MAX_QUEUE   (MAX_QUEUE),
    .COOKIE_BITS (COOKIE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_beat     (in_beat),
    .op          (op),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_beat    (out_beat)
  );

endmodule

// ===== hw/rtl/vqdm_ctrl.sv =====
// Controller state machine of the virtqueue descriptor manager.
// Sequences the datapath through dp_op_t commands; uses vqdm_pkg.
module vqdm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              in_tvalid,
  input  logic              in_is_reclaim,
  output logic              in_tready,
  input  vqdm_pkg::dp_stat_t stat,
  output vqdm_pkg::dp_op_t  op
);

  vqdm_pkg::state_t state_r, state_nxt;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vqdm_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    op        = vqdm_pkg::OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      vqdm_pkg::ST_CLEAR: begin
        op = vqdm_pkg::OP_CLEAR;
        if (stat.clear_last) begin
          state_nxt = vqdm_pkg::ST_IDLE;
        end
      end
      vqdm_pkg::ST_IDLE: begin
        in_tready = !cfg_wr_en;
        if (in_tvalid && !cfg_wr_en) begin
          op        = vqdm_pkg::OP_LATCH;
          state_nxt = in_is_reclaim ? vqdm_pkg::ST_RC_CHK : vqdm_pkg::ST_ADD_RD;
        end
      end
      vqdm_pkg::ST_ADD_RD: begin
        if (stat.full) begin
          if (stat.out_free) begin
            op        = vqdm_pkg::OP_ADD_FULL;
            state_nxt = vqdm_pkg::ST_IDLE;
          end
        end else begin
          op        = vqdm_pkg::OP_ADD_READ;
          state_nxt = vqdm_pkg::ST_ADD_WR;
        end
      end
      vqdm_pkg::ST_ADD_WR: begin
        if (stat.out_free) begin
          op        = vqdm_pkg::OP_ADD_WRITE;
          state_nxt = stat.chain_end ? vqdm_pkg::ST_ADD_PUB : vqdm_pkg::ST_IDLE;
        end
      end
      vqdm_pkg::ST_ADD_PUB: begin
        if (stat.out_free) begin
          op        = vqdm_pkg::OP_ADD_PUB;
          state_nxt = vqdm_pkg::ST_IDLE;
        end
      end
      vqdm_pkg::ST_RC_CHK: begin
        if (stat.no_work) begin
          if (stat.out_free) begin
            op        = vqdm_pkg::OP_RC_NONE;
            state_nxt = vqdm_pkg::ST_IDLE;
          end
        end else begin
          op        = vqdm_pkg::OP_RC_START;
          state_nxt = vqdm_pkg::ST_RC_RD;
        end
      end
      vqdm_pkg::ST_RC_RD: begin
        op        = vqdm_pkg::OP_RC_READ;
        state_nxt = vqdm_pkg::ST_RC_WALK;
      end
      vqdm_pkg::ST_RC_WALK: begin
        if (stat.walk_more) begin
          op = vqdm_pkg::OP_RC_STEP;
        end else if (stat.out_free) begin
          op        = vqdm_pkg::OP_RC_FINISH;
          state_nxt = vqdm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vqdm_pkg::ST_CLEAR;
      end
    endcase

    // A configuration write restarts the clearing pass.
    if (cfg_wr_en) begin
      op        = vqdm_pkg::OP_NONE;
      state_nxt = vqdm_pkg::ST_CLEAR;
    end
  end

endmodule

// ===== hw/rtl/vqdm_datapath.sv =====
// Datapath of the virtqueue descriptor manager: link, chain and cookie
// memories, free list pointers, ring counters and the output register.
// Driven by vqdm_ctrl commands; uses vqdm_pkg.
module vqdm_datapath #(
  parameter int MAX_QUEUE   = vqdm_pkg::MAX_QUEUE_DEF,
  parameter int COOKIE_BITS = vqdm_pkg::COOKIE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  input  vqdm_pkg::in_beat_t  in_beat,
  input  vqdm_pkg::dp_op_t    op,
  output vqdm_pkg::dp_stat_t  stat,
  input  logic                out_tready,
  output logic                out_valid,
  output vqdm_pkg::out_beat_t out_beat
);

  localparam int LGMAX = $clog2(MAX_QUEUE + 1) - 1;
  localparam int AW    = $clog2(MAX_QUEUE);
  localparam int CNTW  = LGMAX + 1;
  localparam int CW    = (COOKIE_BITS < 32) ? COOKIE_BITS : 32;

  // Memories.
  logic [AW-1:0] next_mem  [MAX_QUEUE];
  logic          chain_mem [MAX_QUEUE];
  logic [CW-1:0] cookie_mem[MAX_QUEUE];

  logic [AW-1:0] next_q;
  logic          chain_q;
  logic [CW-1:0] cookie_q;

  // Memory port controls.
  logic          link_rd_en;
  logic [AW-1:0] link_rd_addr;
  logic          nxt_we;
  logic [AW-1:0] nxt_wa, nxt_wd;
  logic          chn_we;
  logic [AW-1:0] chn_wa;
  logic          chn_wd;
  logic          ck_we;
  logic [AW-1:0] ck_wa;
  logic [CW-1:0] ck_wd;
  logic          ck_rd_en;
  logic [AW-1:0] ck_rd_addr;

  // Registers.
  logic [3:0]          qlog_r, qlog_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [AW-1:0]       fl_head_r, fl_head_nxt;
  logic [AW-1:0]       fl_tail_r, fl_tail_nxt;
  logic [CNTW-1:0]     total_r, total_nxt;
  logic [15:0]         avail_r, avail_nxt;
  logic [15:0]         last_used_r, last_used_nxt;
  logic [AW-1:0]       open_head_r, open_head_nxt;
  logic                chain_open_r, chain_open_nxt;
  logic [AW-1:0]       id_r, id_nxt;
  logic [AW-1:0]       cur_r, cur_nxt;
  logic [CNTW-1:0]     count_r, count_nxt;
  vqdm_pkg::in_beat_t  in_r, in_nxt;
  logic                out_valid_r, out_valid_nxt;
  vqdm_pkg::out_beat_t out_r, out_nxt;

  // Queue size derived from the register, saturated at the table size.
  logic [3:0]      lg_eff;
  logic [CNTW-1:0] qn;
  logic [AW-1:0]   qmask;

  // Working values.
  logic [AW-1:0]   d_w, nx_w, head_w, id_w, step_w;
  logic [CNTW:0]   sum_w;
  logic [CNTW-1:0] total_sat_w;
  logic            out_free_w;

  assign lg_eff = (qlog_r > 4'(LGMAX)) ? 4'(LGMAX) : qlog_r;
  assign qn     = CNTW'(1) << lg_eff;
  assign qmask  = AW'(qn - CNTW'(1));

  assign d_w         = fl_head_r & qmask;
  assign nx_w        = next_q & qmask;
  assign head_w      = chain_open_r ? open_head_r : d_w;
  assign id_w        = AW'(in_r.used_head) & qmask;
  assign step_w      = next_q & qmask;
  assign sum_w       = {1'b0, total_r} + {1'b0, count_r};
  assign total_sat_w = (sum_w > {1'b0, qn}) ? qn : sum_w[CNTW-1:0];
  assign out_free_w  = !out_valid_r || out_tready;

  // Status to the controller.
  assign stat.full       = (total_r == '0);
  assign stat.no_work    = (last_used_r == in_r.device_used_index);
  assign stat.chain_end  = in_r.chain_end;
  assign stat.walk_more  = chain_q && (count_r < qn);
  assign stat.clear_last = (clr_r == qmask);
  assign stat.out_free   = out_free_w;

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // Command decode: next state of the registers and memory port controls.
  always_comb begin
    qlog_nxt       = qlog_r;
    clr_nxt        = clr_r;
    fl_head_nxt    = fl_head_r;
    fl_tail_nxt    = fl_tail_r;
    total_nxt      = total_r;
    avail_nxt      = avail_r;
    last_used_nxt  = last_used_r;
    open_head_nxt  = open_head_r;
    chain_open_nxt = chain_open_r;
    id_nxt         = id_r;
    cur_nxt        = cur_r;
    count_nxt      = count_r;
    in_nxt         = in_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    link_rd_en   = 1'b0;
    link_rd_addr = d_w;
    nxt_we       = 1'b0;
    nxt_wa       = clr_r;
    nxt_wd       = '0;
    chn_we       = 1'b0;
    chn_wa       = clr_r;
    chn_wd       = 1'b1;
    ck_we        = 1'b0;
    ck_wa        = id_r;
    ck_wd        = '0;
    ck_rd_en     = 1'b0;
    ck_rd_addr   = id_w;

    case (op)
      vqdm_pkg::OP_LATCH: begin
        in_nxt = in_beat;
      end
      vqdm_pkg::OP_CLEAR: begin
        // One table entry a cycle; the scalars settle on every pass cycle.
        nxt_we         = 1'b1;
        nxt_wa         = clr_r;
        nxt_wd         = (clr_r + AW'(1)) & qmask;
        chn_we         = 1'b1;
        chn_wa         = clr_r;
        chn_wd         = 1'b1;
        clr_nxt        = clr_r + AW'(1);
        fl_head_nxt    = '0;
        fl_tail_nxt    = qmask;
        total_nxt      = qn;
        avail_nxt      = '0;
        last_used_nxt  = '0;
        open_head_nxt  = '0;
        chain_open_nxt = 1'b0;
      end
      vqdm_pkg::OP_ADD_FULL: begin
        out_valid_nxt      = 1'b1;
        out_nxt            = '0;
        out_nxt.kind       = vqdm_pkg::KIND_NOFREE;
        out_nxt.free_count = 9'(total_r);
        out_nxt.last       = 1'b1;
      end
      vqdm_pkg::OP_ADD_READ: begin
        link_rd_en   = 1'b1;
        link_rd_addr = d_w;
      end
      vqdm_pkg::OP_ADD_WRITE: begin
        // Take the free head, mark its chain bit, report the descriptor.
        chn_we         = 1'b1;
        chn_wa         = d_w;
        chn_wd         = !in_r.chain_end;
        fl_head_nxt    = nx_w;
        total_nxt      = total_r - CNTW'(1);
        open_head_nxt  = head_w;
        chain_open_nxt = !in_r.chain_end;
        if (in_r.chain_end) begin
          ck_we     = 1'b1;
          ck_wa     = head_w;
          ck_wd     = CW'(in_r.cookie_in);
          avail_nxt = avail_r + 16'd1;
        end
        out_valid_nxt          = 1'b1;
        out_nxt                = '0;
        out_nxt.kind           = vqdm_pkg::KIND_DESC;
        out_nxt.slot           = 8'(d_w);
        out_nxt.desc_address   = {in_r.buf_addr[63:1], 1'b0};
        out_nxt.desc_length    = in_r.buf_len;
        out_nxt.desc_flag_bits = {in_r.buf_write, !in_r.chain_end};
        out_nxt.head_index     = 8'(nx_w);
        out_nxt.free_count     = 9'(total_r - CNTW'(1));
        out_nxt.last           = !in_r.chain_end;
      end
      vqdm_pkg::OP_ADD_PUB: begin
        // Avail slot is the index before the bump.
        out_valid_nxt       = 1'b1;
        out_nxt             = '0;
        out_nxt.kind        = vqdm_pkg::KIND_PUBLISH;
        out_nxt.slot        = 8'(AW'(avail_r - 16'd1) & qmask);
        out_nxt.head_index  = 8'(open_head_r);
        out_nxt.avail_index = avail_r;
        out_nxt.free_count  = 9'(total_r);
        out_nxt.last        = 1'b1;
      end
      vqdm_pkg::OP_RC_NONE: begin
        out_valid_nxt      = 1'b1;
        out_nxt            = '0;
        out_nxt.kind       = vqdm_pkg::KIND_EMPTY;
        out_nxt.free_count = 9'(total_r);
        out_nxt.last       = 1'b1;
      end
      vqdm_pkg::OP_RC_START: begin
        // Hook the returned chain behind the free tail, fetch its cookie.
        last_used_nxt = last_used_r + 16'd1;
        id_nxt        = id_w;
        if (total_r == '0) begin
          fl_head_nxt = id_w;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = fl_tail_r & qmask;
          nxt_wd = id_w;
        end
        ck_rd_en   = 1'b1;
        ck_rd_addr = id_w;
      end
      vqdm_pkg::OP_RC_READ: begin
        link_rd_en   = 1'b1;
        link_rd_addr = id_r;
        cur_nxt      = id_r;
        count_nxt    = CNTW'(1);
      end
      vqdm_pkg::OP_RC_STEP: begin
        link_rd_en   = 1'b1;
        link_rd_addr = step_w;
        cur_nxt      = step_w;
        count_nxt    = count_r + CNTW'(1);
      end
      vqdm_pkg::OP_RC_FINISH: begin
        // Close the free list at the chain end and report the reclaim.
        fl_tail_nxt   = cur_r;
        nxt_we        = 1'b1;
        nxt_wa        = cur_r;
        nxt_wd        = fl_head_r & qmask;
        chn_we        = 1'b1;
        chn_wa        = cur_r;
        chn_wd        = 1'b1;
        total_nxt     = total_sat_w;
        ck_we         = 1'b1;
        ck_wa         = id_r;
        ck_wd         = '0;
        out_valid_nxt           = 1'b1;
        out_nxt                 = '0;
        out_nxt.kind            = vqdm_pkg::KIND_RECLAIM;
        out_nxt.head_index      = 8'(id_r);
        out_nxt.cookie_out      = 32'(cookie_q);
        out_nxt.returned_length = in_r.used_length;
        out_nxt.freed           = 9'(count_r);
        out_nxt.free_count      = 9'(total_sat_w);
        out_nxt.last            = 1'b1;
      end
      default: begin
      end
    endcase

    // A configuration write restarts the clearing pass at entry zero.
    if (cfg_wr_en) begin
      qlog_nxt = cfg_wr_data;
      clr_nxt  = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlog_r       <= vqdm_pkg::QLOG_RESET;
      clr_r        <= '0;
      fl_head_r    <= '0;
      fl_tail_r    <= '0;
      total_r      <= '0;
      avail_r      <= '0;
      last_used_r  <= '0;
      open_head_r  <= '0;
      chain_open_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      qlog_r       <= qlog_nxt;
      clr_r        <= clr_nxt;
      fl_head_r    <= fl_head_nxt;
      fl_tail_r    <= fl_tail_nxt;
      total_r      <= total_nxt;
      avail_r      <= avail_nxt;
      last_used_r  <= last_used_nxt;
      open_head_r  <= open_head_nxt;
      chain_open_r <= chain_open_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    cur_r   <= cur_nxt;
    count_r <= count_nxt;
    in_r    <= in_nxt;
    out_r   <= out_nxt;
  end

  // Next-link memory with registered read.
  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    if (link_rd_en) begin
      next_q <= next_mem[link_rd_addr];
    end
  end

  // Chain-bit memory, read alongside the next links.
  always_ff @(posedge clk) begin
    if (chn_we) begin
      chain_mem[chn_wa] <= chn_wd;
    end
    if (link_rd_en) begin
      chain_q <= chain_mem[link_rd_addr];
    end
  end

  // Cookie memory, one entry per chain head.
  always_ff @(posedge clk) begin
    if (ck_we) begin
      cookie_mem[ck_wa] <= ck_wd;
    end
    if (ck_rd_en) begin
      cookie_q <= cookie_mem[ck_rd_addr];
    end
  end

endmodule

// ===== hw/rtl/vqdm_checker.sv =====
// Port-level checker for the virtqueue descriptor manager, with its bind.
// Watches the result stream only; uses vqdm_pkg.
module vqdm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [vqdm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]                       out_tuser,
  input logic                             out_tlast
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Only a descriptor write can be followed by another beat of its item.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != vqdm_pkg::KIND_DESC) |-> out_tlast)
    else $error("non-descriptor beat without last");

  // A no-free beat reports an empty free list.
  a_nofree_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == vqdm_pkg::KIND_NOFREE) |-> out_tdata[211:203] == 9'd0)
    else $error("no-free beat with free descriptors");

  // Descriptor addresses always have bit 0 cleared.
  a_addr_bit0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == vqdm_pkg::KIND_DESC) |-> !out_tdata[8])
    else $error("descriptor address bit 0 set");

endmodule

bind virtqueue_descriptor_manager_core vqdm_checker u_vqdm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
